// ===== sv/kcl_pkg.sv =====
// Shared types, codes and constants of the keypad code lock controller.
package kcl_pkg;

  // Digits held in one entry and in the stored user code
  localparam int CODE_DIGITS = 4;
  localparam int CntW        = $clog2(CODE_DIGITS + 1);

  // Master code is always four BCD digits, first digit in the top nibble
  localparam int          MasterLen   = 4;
  localparam int          MasterCmp   = (CODE_DIGITS < MasterLen) ? CODE_DIGITS : MasterLen;
  localparam logic [15:0] MasterReset = 16'h1234;

  // Input operation codes
  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_OPEN   = 2'd1;
  localparam logic [1:0] OP_ENROLL = 2'd2;

  // Key codes beyond the digits
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_CLEAR     = 4'd10;
  localparam logic [3:0] KEY_ENTER     = 4'd11;

  typedef enum logic [3:0] {
    ACT_IGNORED = 4'd0,
    ACT_DIGIT   = 4'd1,
    ACT_CLEARED = 4'd2,
    ACT_OPEN    = 4'd3,
    ACT_WRONG   = 4'd4,
    ACT_OLD_OK  = 4'd5,
    ACT_REJECT  = 4'd6,
    ACT_SAVED   = 4'd7,
    ACT_ENROLL  = 4'd8
  } action_e;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_VERIFY = 2'd1,
    MODE_NEW    = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] key;
  } kcl_in_t;

  typedef struct packed {
    action_e    action;
    logic [3:0] echo_digit;
    mode_e      mode;
  } kcl_out_t;

endpackage

// ===== sv/keypad_code_lock_controller_top.sv =====
// Keypad code lock controller: entry collection, code compare, enroll flow.
//
// One beat in, one beat out. Each accepted beat (key press, open button or
// enroll button) is decoded combinationally against the held entry, the stored
// user code and the master code register, and its result lands in the output
// register on the same edge as the state update, so the block takes one beat
// per cycle; the only limit is the output register, which accepts a new beat
// whenever it is empty or its result is taken in that cycle.
// master_code may be written at any idle time; it resets to 0x1234.
module keypad_code_lock_controller_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kcl_pkg::kcl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kcl_pkg::kcl_out_t out_data_o
);

  logic [15:0]               master_q;
  logic [3:0]                entry_q [kcl_pkg::CODE_DIGITS];
  logic [3:0]                entry_d [kcl_pkg::CODE_DIGITS];
  logic [kcl_pkg::CntW-1:0]  entry_cnt_q, entry_cnt_d;
  logic [3:0]                user_q  [kcl_pkg::CODE_DIGITS];
  logic [3:0]                user_d  [kcl_pkg::CODE_DIGITS];
  logic [kcl_pkg::CntW-1:0]  user_len_q, user_len_d;
  kcl_pkg::mode_e            mode_q, mode_d;
  logic                      out_valid_q;
  kcl_pkg::kcl_out_t         out_q, out_d;

  logic                      accept;
  logic                      hit_master, hit_user, hit;
  logic [3:0]                master_nib [kcl_pkg::MasterLen];

  // Take a beat whenever the output register is free or drains now
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Split master code into digits, first digit on top
  always_comb begin
    for (int i = 0; i < kcl_pkg::MasterLen; i++) begin
      master_nib[i] = master_q[15 - 4*i -: 4];
    end
  end

  // Compare entry against master and user codes
  always_comb begin
    hit_master = (kcl_pkg::CODE_DIGITS >= kcl_pkg::MasterLen) &&
                 (entry_cnt_q == kcl_pkg::CntW'(kcl_pkg::MasterLen));
    for (int i = 0; i < kcl_pkg::MasterCmp; i++) begin
      if (entry_q[i] != master_nib[i]) hit_master = 1'b0;
    end
    hit_user = (entry_cnt_q == user_len_q);
    for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) begin
      if ((kcl_pkg::CntW'(i) < entry_cnt_q) && (entry_q[i] != user_q[i])) hit_user = 1'b0;
    end
    hit = hit_master || hit_user;
  end

  // Decode one beat into next state and its result
  always_comb begin
    entry_d     = entry_q;
    entry_cnt_d = entry_cnt_q;
    user_d      = user_q;
    user_len_d  = user_len_q;
    mode_d      = mode_q;
    out_d.action     = kcl_pkg::ACT_IGNORED;
    out_d.echo_digit = 4'd0;
    unique case (in_data_i.op)
      kcl_pkg::OP_OPEN: begin
        out_d.action = kcl_pkg::ACT_OPEN;
      end
      kcl_pkg::OP_ENROLL: begin
        mode_d       = kcl_pkg::MODE_VERIFY;
        entry_cnt_d  = '0;
        out_d.action = kcl_pkg::ACT_ENROLL;
      end
      kcl_pkg::OP_KEY: begin
        if (in_data_i.key <= kcl_pkg::KEY_DIGIT_MAX) begin
          // Append digit unless the entry is full
          if (entry_cnt_q < kcl_pkg::CntW'(kcl_pkg::CODE_DIGITS)) begin
            for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) begin
              if (entry_cnt_q == kcl_pkg::CntW'(i)) entry_d[i] = in_data_i.key;
            end
            entry_cnt_d      = entry_cnt_q + kcl_pkg::CntW'(1);
            out_d.action     = kcl_pkg::ACT_DIGIT;
            out_d.echo_digit = in_data_i.key;
          end
        end else if (in_data_i.key == kcl_pkg::KEY_CLEAR) begin
          entry_cnt_d  = '0;
          out_d.action = kcl_pkg::ACT_CLEARED;
        end else if (in_data_i.key == kcl_pkg::KEY_ENTER) begin
          entry_cnt_d = '0;
          unique case (mode_q)
            kcl_pkg::MODE_VERIFY: begin
              mode_d       = hit ? kcl_pkg::MODE_NEW : kcl_pkg::MODE_NORMAL;
              out_d.action = hit ? kcl_pkg::ACT_OLD_OK : kcl_pkg::ACT_REJECT;
            end
            kcl_pkg::MODE_NEW: begin
              // Save the entry as the new user code
              user_d       = entry_q;
              user_len_d   = entry_cnt_q;
              mode_d       = kcl_pkg::MODE_NORMAL;
              out_d.action = kcl_pkg::ACT_SAVED;
            end
            default: begin
              mode_d       = kcl_pkg::MODE_NORMAL;
              out_d.action = hit ? kcl_pkg::ACT_OPEN : kcl_pkg::ACT_WRONG;
            end
          endcase
        end
      end
      default: begin
        out_d.action = kcl_pkg::ACT_IGNORED;
      end
    endcase
    out_d.mode = mode_d;
  end

  // Hold control state and master code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q    <= kcl_pkg::MasterReset;
      entry_cnt_q <= '0;
      user_len_q  <= '0;
      mode_q      <= kcl_pkg::MODE_NORMAL;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) master_q <= cfg_wdata_i;
      if (accept) begin
        entry_cnt_q <= entry_cnt_d;
        user_len_q  <= user_len_d;
        mode_q      <= mode_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold digit stores and the result beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
      user_q  <= user_d;
      out_q   <= out_d;
    end
  end

  // Entry never holds more digits than the store has
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_cnt_q <= kcl_pkg::CntW'(kcl_pkg::CODE_DIGITS)) &&
    (user_len_q <= kcl_pkg::CntW'(kcl_pkg::CODE_DIGITS)))
    else $error("entry or user code length out of range");

  // Enroll beat leaves an empty entry in verify mode
  a_enroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_data_i.op == kcl_pkg::OP_ENROLL) |=>
      (mode_q == kcl_pkg::MODE_VERIFY) && (entry_cnt_q == '0))
    else $error("enroll did not enter verify mode with an empty entry");

  // Fresh result reports the mode that the state now holds
  a_mode_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q && (out_q.mode == mode_q))
    else $error("result mode differs from held mode");

  // A result appears only after a beat was taken
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(accept))
    else $error("result appeared without an accepted beat");

endmodule
